@@ sv/rilx_pkg.sv @@
// Shared types, codes and constants of the radix integer lexer.
package rilx_pkg;

    localparam int CharW  = 21;
    localparam int CountW = 7;
    localparam int ValueW = 64;

    typedef enum logic {
        OP_START = 1'b0,
        OP_CHAR  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        RADIX_DEC  = 2'd0,
        RADIX_HEX  = 2'd1,
        RADIX_BIN  = 2'd2,
        RADIX_RSVD = 2'd3
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_LEAD_SEP   = 3'd2,
        ST_DOUBLE_SEP = 3'd3,
        ST_NO_DIGIT   = 3'd4,
        ST_LIMIT      = 3'd5,
        ST_END        = 3'd6,
        ST_RSVD       = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        CFG_SEP_CODE = 2'd0,
        CFG_MAX_DEC  = 2'd1,
        CFG_MAX_HEX  = 2'd2,
        CFG_MAX_BIN  = 2'd3
    } cfg_idx_t;

    localparam logic [CharW-1:0]  SepCodeReset = 21'd39;
    localparam logic [CountW-1:0] MaxDecReset  = 7'd19;
    localparam logic [CountW-1:0] MaxHexReset  = 7'd16;
    localparam logic [CountW-1:0] MaxBinReset  = 7'd64;

    // One input beat, unpacked.
    typedef struct packed {
        op_t               op;
        radix_t            radix;
        logic              negative;
        logic              sep_allowed;
        logic [CountW-1:0] fixed_digits;
        logic [CharW-1:0]  char_code;
        logic              end_of_data;
    } item_t;

    typedef struct packed {
        logic [CharW-1:0]  sep_code;
        logic [CountW-1:0] max_dec;
        logic [CountW-1:0] max_hex;
        logic [CountW-1:0] max_bin;
    } cfg_t;

    // Handoff from the digit stage to the result stage.
    typedef struct packed {
        logic              is_error;
        status_t           status;
        logic [ValueW-1:0] acc;
        logic [CountW-1:0] count;
        logic              negative;
        logic [CountW-1:0] fixed_digits;
        logic              consumed;
    } pend_t;

    typedef struct packed {
        logic [ValueW-1:0] value;
        logic [CountW-1:0] digits;
        status_t           status;
        logic              consumed;
    } result_t;

endpackage

@@ sv/rilx_step.sv @@
// Digit stage: number state registers and per-character accumulate and check logic.
module rilx_step #(
    parameter int DIGIT_LIMIT = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  rilx_pkg::item_t  item,
    input  rilx_pkg::cfg_t   cfg,
    output logic             emit,
    output rilx_pkg::pend_t  pend
);
    import rilx_pkg::*;

    localparam logic [CountW-1:0] DigitCap = CountW'(DIGIT_LIMIT);

    logic [ValueW-1:0] acc_reg, acc_next;
    logic [CountW-1:0] cnt_reg, cnt_next;
    logic              sep_pend_reg, sep_pend_next;
    logic              active_reg, active_next;
    radix_t            radix_reg, radix_next;
    logic              neg_reg, neg_next;
    logic              sep_ok_reg, sep_ok_next;
    logic [CountW-1:0] fixed_reg, fixed_next;

    logic [4:0]        digit_raw;
    logic [4:0]        base;
    logic              is_digit;
    logic [CountW-1:0] lim_raw;
    logic [CountW-1:0] lim;
    logic [ValueW+4:0] prod;
    logic [ValueW+4:0] sum;
    logic              ovf;
    logic [CountW-1:0] cnt_inc;
    logic              is_sep;

    // Digit decode
    always_comb begin
        digit_raw = 5'd16;
        if (item.char_code >= 21'h30 && item.char_code <= 21'h39) begin
            digit_raw = 5'(item.char_code - 21'h30);
        end else if (item.char_code >= 21'h61 && item.char_code <= 21'h66) begin
            digit_raw = 5'(item.char_code - 21'h57);
        end else if (item.char_code >= 21'h41 && item.char_code <= 21'h46) begin
            digit_raw = 5'(item.char_code - 21'h37);
        end
        unique case (radix_reg)
            RADIX_HEX: begin base = 5'd16; lim_raw = cfg.max_hex; end
            RADIX_BIN: begin base = 5'd2;  lim_raw = cfg.max_bin; end
            default:   begin base = 5'd10; lim_raw = cfg.max_dec; end
        endcase
        is_digit = digit_raw < base;
        lim      = (lim_raw > DigitCap) ? DigitCap : lim_raw;
    end

    // Multiply by the base as shift and add; any carry past bit 63 is overflow
    always_comb begin
        unique case (radix_reg)
            RADIX_HEX: prod = {1'b0, acc_reg, 4'b0};
            RADIX_BIN: prod = {4'b0, acc_reg, 1'b0};
            default:   prod = {2'b0, acc_reg, 3'b0} + {4'b0, acc_reg, 1'b0};
        endcase
        sum     = prod + (ValueW+5)'(digit_raw[3:0]);
        ovf     = |sum[ValueW+4:ValueW];
        cnt_inc = cnt_reg + 7'd1;
        is_sep  = item.char_code == cfg.sep_code;
    end

    always_comb begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        sep_pend_next = sep_pend_reg;
        active_next   = active_reg;
        radix_next    = radix_reg;
        neg_next      = neg_reg;
        sep_ok_next   = sep_ok_reg;
        fixed_next    = fixed_reg;
        emit          = 1'b0;
        pend.is_error     = 1'b1;
        pend.status       = ST_OK;
        pend.acc          = acc_reg;
        pend.count        = cnt_reg;
        pend.negative     = neg_reg;
        pend.fixed_digits = fixed_reg;
        pend.consumed     = 1'b0;

        if (item.op == OP_START) begin
            radix_next    = item.radix;
            neg_next      = item.negative;
            sep_ok_next   = item.sep_allowed;
            fixed_next    = item.fixed_digits;
            acc_next      = '0;
            cnt_next      = '0;
            sep_pend_next = 1'b0;
            active_next   = 1'b1;
        end else if (active_reg) begin
            if (item.end_of_data) begin
                emit = 1'b1;
                if (sep_pend_reg || cnt_reg == '0) begin
                    pend.status = ST_END;
                end else begin
                    pend.is_error = 1'b0;
                end
            end else if (sep_ok_reg && !sep_pend_reg && is_sep) begin
                if (cnt_reg == '0) begin
                    emit        = 1'b1;
                    pend.status = ST_LEAD_SEP;
                end else begin
                    sep_pend_next = 1'b1;
                end
            end else if (sep_pend_reg && is_sep) begin
                emit        = 1'b1;
                pend.status = ST_DOUBLE_SEP;
            end else if (sep_pend_reg && !is_digit) begin
                emit        = 1'b1;
                pend.status = ST_NO_DIGIT;
            end else if (!is_digit) begin
                // Non-digit ends the number and is left for the caller
                emit          = 1'b1;
                pend.is_error = 1'b0;
            end else if (cnt_reg >= lim || ovf) begin
                emit        = 1'b1;
                pend.status = ST_LIMIT;
            end else begin
                sep_pend_next = 1'b0;
                acc_next      = sum[ValueW-1:0];
                cnt_next      = cnt_inc;
                if (fixed_reg != '0 && cnt_inc >= fixed_reg) begin
                    emit          = 1'b1;
                    pend.is_error = 1'b0;
                    pend.acc      = sum[ValueW-1:0];
                    pend.count    = cnt_inc;
                    pend.consumed = 1'b1;
                end
            end
        end

        if (emit) begin
            active_next   = 1'b0;
            sep_pend_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            cnt_reg      <= '0;
            sep_pend_reg <= 1'b0;
            active_reg   <= 1'b0;
            radix_reg    <= RADIX_DEC;
            neg_reg      <= 1'b0;
            sep_ok_reg   <= 1'b0;
            fixed_reg    <= '0;
        end else if (fire) begin
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            sep_pend_reg <= sep_pend_next;
            active_reg   <= active_next;
            radix_reg    <= radix_next;
            neg_reg      <= neg_next;
            sep_ok_reg   <= sep_ok_next;
            fixed_reg    <= fixed_next;
        end
    end

endmodule

@@ sv/rilx_final.sv @@
// Result stage logic: fixed-count check, sign application and signed range check.
module rilx_final (
    input  rilx_pkg::pend_t   pend,
    output rilx_pkg::result_t res
);
    import rilx_pkg::*;

    logic neg_over;

    assign neg_over = pend.acc[ValueW-1] && (|pend.acc[ValueW-2:0]);

    always_comb begin
        res.digits   = pend.count;
        res.consumed = pend.consumed;
        res.value    = '0;
        res.status   = pend.status;
        if (!pend.is_error) begin
            if (pend.fixed_digits != '0 && pend.count < pend.fixed_digits) begin
                res.value  = '1;
                res.status = ST_SHORT;
            end else if (pend.negative) begin
                if (neg_over) begin
                    res.status = ST_LIMIT;
                end else begin
                    // Two's complement; the most negative value maps onto itself
                    res.value  = ValueW'(0) - pend.acc;
                    res.status = ST_OK;
                end
            end else if (pend.acc[ValueW-1]) begin
                res.status = ST_LIMIT;
            end else begin
                res.value  = pend.acc;
                res.status = ST_OK;
            end
        end
    end

endmodule

@@ sv/radix_integer_lexer.sv @@
// Top level of the radix integer lexer: stream ports, config registers, pipeline control.
//
// Usage:
//   s_ channel: one beat is a start item (s_tuser[0] = 0) that opens a number with its
//   base, sign, separator permission and optional fixed digit count, or a character item
//   (s_tuser[0] = 1) carrying one code point, or end of data when s_tuser[1] is set.
//   m_ channel: one beat per finished number: signed value and digit count in m_tdata,
//   status and the char-consumed flag in m_tuser. A number that ends on a non-digit
//   leaves that character unconsumed; the caller re-presents it elsewhere.
//   cfg channel: write separator code and per-base digit limits while the block is idle;
//   cfg_ready is always high.
// Timing:
//   One beat per cycle in sustained flow while m_tready stays high. The input register
//   loads at the edge that accepts a beat, the digit stage (multiply by base as shift-add
//   and 64-bit overflow check) then loads its output register, and the result stage
//   (sign and range check) then loads the output register that drives m_.
// Reset:
//   aresetn low clears all pipeline valids and number state and restores the register
//   defaults (separator 39, digit limits 19/16/64).
// Stall:
//   When m_tready is low and a result is waiting, the output register holds; the stages
//   behind it fill and then s_tready drops. No beat is lost or repeated.
module radix_integer_lexer #(
    parameter int DIGIT_LIMIT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // radix_select[1:0], is_negative, separators_allowed,
                                   // fixed_digits[6:0], char_code[20:0]
    input  logic [1:0]  s_tuser,   // op, end_of_data
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // number_value[63:0], digits_read[6:0], zero pad
    output logic [3:0]  m_tuser,   // status[2:0], char_consumed
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    import rilx_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_reg;
    logic    in_vld_reg;
    pend_t   fin_reg;
    logic    fin_vld_reg;
    result_t out_reg;
    logic    out_vld_reg;

    item_t   s_item;
    logic    out_free, fin_fire, fin_free, proc_fire;
    logic    emit;
    pend_t   pend;
    result_t res;

    // Unpack the input beat
    assign s_item.op           = op_t'(s_tuser[0]);
    assign s_item.end_of_data  = s_tuser[1];
    assign s_item.radix        = radix_t'(s_tdata[1:0]);
    assign s_item.negative     = s_tdata[2];
    assign s_item.sep_allowed  = s_tdata[3];
    assign s_item.fixed_digits = s_tdata[10:4];
    assign s_item.char_code    = s_tdata[31:11];

    // Ready chain: each stage advances when the one ahead is empty or draining
    assign out_free  = !out_vld_reg || m_tready;
    assign fin_fire  = fin_vld_reg && out_free;
    assign fin_free  = !fin_vld_reg || fin_fire;
    assign proc_fire = in_vld_reg && fin_free;
    assign s_tready  = !in_vld_reg || proc_fire;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sep_code <= SepCodeReset;
            cfg_reg.max_dec  <= MaxDecReset;
            cfg_reg.max_hex  <= MaxHexReset;
            cfg_reg.max_bin  <= MaxBinReset;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SEP_CODE: cfg_reg.sep_code <= cfg_data;
                CFG_MAX_DEC:  cfg_reg.max_dec  <= cfg_data[CountW-1:0];
                CFG_MAX_HEX:  cfg_reg.max_hex  <= cfg_data[CountW-1:0];
                CFG_MAX_BIN:  cfg_reg.max_bin  <= cfg_data[CountW-1:0];
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= s_item;
        end
    end

    rilx_step #(
        .DIGIT_LIMIT(DIGIT_LIMIT)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (proc_fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .pend    (pend)
    );

    // Digit stage output register: loaded only when the item ends a number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (proc_fire && emit) begin
            fin_vld_reg <= 1'b1;
        end else if (fin_fire) begin
            fin_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            fin_reg <= pend;
        end
    end

    rilx_final u_final (
        .pend (fin_reg),
        .res  (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= fin_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg.digits, out_reg.value};
    assign m_tuser  = {out_reg.consumed, out_reg.status};

    // Backpressure reaches the input only when both later stages are full and stalled
    a_stall_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (fin_vld_reg && m_tvalid && !m_tready))
        else $error("input stalled without a full, stalled pipeline");

    // Error statuses carry a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status != ST_OK && out_reg.status != ST_SHORT)
        |-> out_reg.value == '0)
        else $error("error result with nonzero value");

    // A short fixed count reports minus one
    a_short_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status == ST_SHORT) |-> (&out_reg.value))
        else $error("short fixed count without value -1");

    // A consumed character is always a counted digit
    a_consumed_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.consumed) |-> (out_reg.digits != '0
        && out_reg.status != ST_SHORT))
        else $error("consumed flag on a result without a final digit");

endmodule
